FILE: hdl/braille_cell_dominant_color_top_defines.svh
// Assertion macros used by the checker file.
`ifndef BRAILLE_CELL_DOMINANT_COLOR_TOP_DEFINES_SVH
`define BRAILLE_CELL_DOMINANT_COLOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDC_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("bdc check failed: implication");

// Implication whose consequent is checked after a delay given by n.
`define BDC_ASSERT_DLY(label, clk, rst_n, a, n, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error("bdc check failed: delayed implication");

`endif

FILE: hdl/bdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdc_pkg;

    localparam int unsigned NUM_DOTS = 8;
    localparam logic [7:0] BLACK_COLOR = 8'd0;

    // Palette index to terminal 256-color index.
    localparam logic [7:0] PALETTE_MAP [64] = '{
        8'd244, 8'd25,  8'd19,  8'd54,  8'd125, 8'd160, 8'd124, 8'd88,
        8'd52,  8'd22,  8'd22,  8'd22,  8'd23,  8'd0,   8'd0,   8'd0,
        8'd251, 8'd33,  8'd27,  8'd99,  8'd199, 8'd197, 8'd196, 8'd166,
        8'd166, 8'd64,  8'd28,  8'd29,  8'd32,  8'd234, 8'd0,   8'd0,
        8'd231, 8'd45,  8'd75,  8'd177, 8'd207, 8'd210, 8'd209, 8'd214,
        8'd214, 8'd148, 8'd47,  8'd49,  8'd51,  8'd240, 8'd0,   8'd0,
        8'd231, 8'd159, 8'd159, 8'd183, 8'd219, 8'd217, 8'd223, 8'd229,
        8'd229, 8'd186, 8'd157, 8'd158, 8'd159, 8'd253, 8'd0,   8'd0
    };

    typedef struct packed {
        logic [5:0] pix0;
        logic [5:0] pix1;
        logic [5:0] pix2;
        logic [5:0] pix3;
        logic [5:0] pix4;
        logic [5:0] pix5;
        logic [5:0] pix6;
        logic [5:0] pix7;
        logic [7:0] present;
    } bdc_cell_t;

    typedef struct packed {
        logic [7:0] cell_color;
        logic [7:0] dot_mask;
        logic       draw;
    } bdc_result_t;

    // Mapped colors and vote counts between the count and select stages.
    typedef struct packed {
        logic [NUM_DOTS-1:0][7:0] color;
        logic [NUM_DOTS-1:0][3:0] count;
        logic [NUM_DOTS-1:0]      mask;
    } bdc_vote_t;

endpackage

`default_nettype wire

FILE: hdl/bdc_count.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 1: palette lookup, presence masking and per-dot match counts.
module bdc_count (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid,
    input  bdc_pkg::bdc_cell_t     dots,
    output logic                   vote_valid,
    output bdc_pkg::bdc_vote_t     vote
);
    import bdc_pkg::*;

    logic [NUM_DOTS-1:0][5:0] pix;
    logic [NUM_DOTS-1:0][7:0] color;
    logic [NUM_DOTS-1:0]      mask;
    bdc_vote_t                vote_next;
    bdc_vote_t                vote_reg;
    logic                     valid_reg;

    assign pix = {dots.pix7, dots.pix6, dots.pix5, dots.pix4,
                  dots.pix3, dots.pix2, dots.pix1, dots.pix0};

    always_comb
    begin
        for (int k = 0; k < NUM_DOTS; k++)
        begin
            color[k] = dots.present[k] ? PALETTE_MAP[pix[k]] : BLACK_COLOR;
            mask[k]  = (color[k] != BLACK_COLOR);
        end
    end

    // Black dots get a zero count so they never win the vote.
    always_comb
    begin
        vote_next.color = color;
        vote_next.mask  = mask;
        for (int k = 0; k < NUM_DOTS; k++)
        begin
            vote_next.count[k] = 4'd0;
            if (mask[k])
            begin
                for (int j = 0; j < NUM_DOTS; j++)
                begin
                    vote_next.count[k] = vote_next.count[k]
                                       + {3'd0, (color[j] == color[k])};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vote_reg <= vote_next;
    end

    assign vote_valid = valid_reg;
    assign vote       = vote_reg;

endmodule

`default_nettype wire

FILE: hdl/bdc_select.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 2: pick the highest count; strict compare keeps the first dot on ties.
module bdc_select (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              vote_valid,
    input  bdc_pkg::bdc_vote_t     vote,
    output logic                   done,
    output bdc_pkg::bdc_result_t   result
);
    import bdc_pkg::*;

    logic [7:0]  best_color;
    logic [3:0]  best_count;
    bdc_result_t result_next;
    bdc_result_t result_reg;
    logic        done_reg;

    always_comb
    begin
        best_color = BLACK_COLOR;
        best_count = 4'd0;
        for (int k = 0; k < NUM_DOTS; k++)
        begin
            if (vote.count[k] > best_count)
            begin
                best_count = vote.count[k];
                best_color = vote.color[k];
            end
        end
        result_next.cell_color = best_color;
        result_next.dot_mask   = vote.mask;
        result_next.draw       = (best_color != BLACK_COLOR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vote_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: hdl/braille_cell_dominant_color_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Braille cell dominant color.
// Command channel: drive a cell (eight palette indices plus a present mask)
// on "dots" and raise "start"; the transfer happens at a rising edge where
// start is high and busy is low. Result channel: "done" is high for exactly
// one cycle while "result" holds color, dot mask and draw flag; the
// receiver takes it at the edge ending that cycle and cannot stall it.
// Pipeline: a cell passes the input register, the count stage and the
// select stage in that order; done and result are both driven straight
// from registers in the select stage.
// Throughput: one cell per cycle; busy is low whenever not in reset recovery,
// so cells may be issued back to back, each pipeline stage holding one cell.
// The per-cycle work is set by the eight-way match count in the count stage.
// Reset: busy is high while rst_n is low and until its register is first
// clocked again; all valid flags clear, so no stray done strobe appears.
module braille_cell_dominant_color_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  bdc_pkg::bdc_cell_t     dots,
    output logic                   busy,
    output logic                   done,
    output bdc_pkg::bdc_result_t   result
);
    import bdc_pkg::*;

    logic       busy_reg;
    logic       valid_reg;
    bdc_cell_t  cell_reg;
    logic       vote_valid;
    bdc_vote_t  vote;
    logic       accept;

    // One transfer per edge whenever not in reset recovery.
    assign accept = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= 1'b0;
            valid_reg <= accept;
        end
    end

    // Input register: the cell is captured at the accepting edge.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_reg <= dots;
        end
    end

    bdc_count u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (valid_reg),
        .dots       (cell_reg),
        .vote_valid (vote_valid),
        .vote       (vote)
    );

    bdc_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .vote_valid (vote_valid),
        .vote       (vote),
        .done       (done),
        .result     (result)
    );

    assign busy = busy_reg;

endmodule

`default_nettype wire

FILE: hdl/bdc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "braille_cell_dominant_color_top_defines.svh"

module bdc_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic              done,
    input  bdc_pkg::bdc_result_t   result
);
    import bdc_pkg::*;

    // Every accepted cell yields a done strobe.
    `BDC_ASSERT_DLY(a_latency, clk, rst_n, start && !busy, 3, done)

    // No strobe without a matching transfer.
    `BDC_ASSERT_IMP(a_no_spurious, clk, rst_n, done, $past(start && !busy, 3))

    // Draw flag agrees with the dot mask.
    `BDC_ASSERT_IMP(a_draw_mask, clk, rst_n, done, result.draw == (result.dot_mask != 8'd0))

    // Color is black exactly when nothing is drawn.
    `BDC_ASSERT_IMP(a_draw_color, clk, rst_n, done,
        result.draw == (result.cell_color != BLACK_COLOR))

endmodule

bind braille_cell_dominant_color_top bdc_checker u_bdc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
